FILE: rtl/jkeq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jkeq_pkg
// Shared types, codes and reset values for the joystick key event qualifier.
// ----------------------------------------------------------------------------
package jkeq_pkg;

    localparam int TIME_BITS_DEF = 32;

    // Event list of one sample
    localparam int MAX_EVENTS = 6;
    localparam int CNT_W      = $clog2(MAX_EVENTS + 1);
    localparam int IDX_W      = $clog2(MAX_EVENTS);

    // Bundle queue between classifier and serializer (power of two)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ON_TH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_TH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd3;

    localparam logic [1:0] MODE_DIGITAL = 2'd0;
    localparam logic [1:0] MODE_ANALOG  = 2'd1;
    localparam logic [1:0] MODE_MOUSE   = 2'd2;

    localparam logic [6:0]  ON_TH_RST   = 7'd50;
    localparam logic [6:0]  OFF_TH_RST  = 7'd40;
    localparam logic [15:0] TIMEOUT_RST = 16'd500;

    // Held flag bits
    localparam int FLAG_UP    = 0;
    localparam int FLAG_DOWN  = 1;
    localparam int FLAG_LEFT  = 2;
    localparam int FLAG_RIGHT = 3;
    localparam int FLAG_BTN   = 4;

    // Event codes; key up..right follow the flag order, as do mouse up..right
    localparam logic [3:0] EV_KEY_UP      = 4'd0;
    localparam logic [3:0] EV_KEY_BUTTON  = 4'd4;
    localparam logic [3:0] EV_PAD_BUTTON  = 4'd5;
    localparam logic [3:0] EV_MOUSE_UP    = 4'd6;
    localparam logic [3:0] EV_MOUSE_LEFT  = 4'd10;
    localparam logic [3:0] EV_MOUSE_RIGHT = 4'd11;

    typedef struct packed {
        logic [3:0] code;
        logic       pressed;
    } event_t;

    typedef struct packed {
        logic [CNT_W-1:0]            count;
        event_t [MAX_EVENTS-1:0]     ev;
    } bundle_t;

endpackage

FILE: rtl/jkeq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jkeq_front
// Holds configuration and key state, classifies each sample into an ordered
// list of press/release events and pushes non-empty lists to the queue.
// ----------------------------------------------------------------------------
module jkeq_front #(
    parameter int TIME_BITS = jkeq_pkg::TIME_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [jkeq_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [jkeq_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [7:0]                    sample_x,
    input  logic signed [7:0]                    sample_y,
    input  logic                                 button_down,
    input  logic [31:0]                          time_ms,
    input  logic                                 queue_full,
    output logic                                 push,
    output jkeq_pkg::bundle_t                    push_bundle
);
    import jkeq_pkg::*;

    logic [1:0]           mode_reg;
    logic [6:0]           on_reg;
    logic [6:0]           off_reg;
    logic [15:0]          timeout_reg;

    logic [4:0]           held_reg, held_next;
    logic [TIME_BITS-1:0] start_reg, start_next;
    logic                 click_reg, click_next;
    logic                 motion_reg, motion_next;

    logic signed [8:0]    sx, sy, on_p, on_n, off_p, off_n;
    logic [3:0]           beyond, inner, dir_press, dir_rel;
    logic                 moved, btn_held, btn_press, btn_rel, timed_out, accept;
    logic [TIME_BITS-1:0] now, elapsed;

    event_t [MAX_EVENTS-1:0] cand;
    logic   [MAX_EVENTS-1:0] cand_v;
    bundle_t                 bundle;

    assign sx    = {sample_x[7], sample_x};
    assign sy    = {sample_y[7], sample_y};
    assign on_p  = {2'b00, on_reg};
    assign off_p = {2'b00, off_reg};
    assign on_n  = -on_p;
    assign off_n = -off_p;

    assign beyond[FLAG_UP]    = sy < on_n;
    assign beyond[FLAG_DOWN]  = sy > on_p;
    assign beyond[FLAG_LEFT]  = sx < on_n;
    assign beyond[FLAG_RIGHT] = sx > on_p;
    assign inner[FLAG_UP]     = sy > off_n;
    assign inner[FLAG_DOWN]   = sy < off_p;
    assign inner[FLAG_LEFT]   = sx > off_n;
    assign inner[FLAG_RIGHT]  = sx < off_p;

    // a held direction releases whenever it is back inside off, even if
    // off lies above on
    assign dir_press = beyond & ~held_reg[3:0];
    assign dir_rel   = inner & held_reg[3:0];
    assign moved     = |beyond;

    assign btn_held  = held_reg[FLAG_BTN];
    assign btn_press = button_down & ~btn_held;
    assign btn_rel   = ~button_down & btn_held;

    assign now       = time_ms[TIME_BITS-1:0];
    assign elapsed   = now - start_reg;
    assign timed_out = elapsed >= TIME_BITS'(timeout_reg);

    always_comb
    begin
        logic [1:0] fl;
        fl          = '0;
        cand        = '0;
        cand_v      = '0;
        held_next   = held_reg;
        start_next  = start_reg;
        click_next  = click_reg;
        motion_next = motion_reg;
        case (mode_reg)
            MODE_DIGITAL:
            begin
                for (int f = 0; f < 4; f++)
                begin
                    cand_v[f]       = dir_press[f] | dir_rel[f];
                    cand[f].code    = EV_KEY_UP + 4'(f);
                    cand[f].pressed = dir_press[f];
                end
                held_next[3:0]     = dir_press | (held_reg[3:0] & ~dir_rel);
                cand_v[4]          = btn_press | btn_rel;
                cand[4].code       = EV_KEY_BUTTON;
                cand[4].pressed    = btn_press;
                held_next[FLAG_BTN] = button_down;
            end
            MODE_ANALOG:
            begin
                cand_v[4]           = btn_press | btn_rel;
                cand[4].code        = EV_PAD_BUTTON;
                cand[4].pressed     = btn_press;
                held_next[FLAG_BTN] = button_down;
            end
            MODE_MOUSE:
            begin
                // mouse order is left, right, up, down
                for (int s = 0; s < 4; s++)
                begin
                    fl              = 2'(s + 2);
                    cand_v[s]       = dir_press[fl] | dir_rel[fl];
                    cand[s].code    = EV_MOUSE_UP + 4'(fl);
                    cand[s].pressed = dir_press[fl];
                end
                held_next[3:0] = dir_press | (held_reg[3:0] & ~dir_rel);
                if (btn_press)
                begin
                    start_next          = now;
                    click_next          = 1'b0;
                    motion_next         = 1'b0;
                    held_next[FLAG_BTN] = 1'b1;
                end
                else if (btn_rel)
                begin
                    cand_v[4] = 1'b1;
                    if (click_reg)
                    begin
                        // free the click that was actually issued
                        cand[4].code    = motion_reg ? EV_MOUSE_LEFT : EV_MOUSE_RIGHT;
                        cand[4].pressed = 1'b0;
                    end
                    else
                    begin
                        // quick tap: left press then release
                        cand[4].code    = EV_MOUSE_LEFT;
                        cand[4].pressed = 1'b1;
                        cand_v[5]       = 1'b1;
                        cand[5].code    = EV_MOUSE_LEFT;
                        cand[5].pressed = 1'b0;
                    end
                    held_next[FLAG_BTN] = 1'b0;
                    click_next          = 1'b0;
                    motion_next         = 1'b0;
                end
                else if (button_down && !click_reg)
                begin
                    if (moved)
                    begin
                        motion_next     = 1'b1;
                        cand_v[4]       = 1'b1;
                        cand[4].code    = EV_MOUSE_LEFT;
                        cand[4].pressed = 1'b1;
                        click_next      = 1'b1;
                    end
                    else if (timed_out)
                    begin
                        cand_v[4]       = 1'b1;
                        cand[4].code    = EV_MOUSE_RIGHT;
                        cand[4].pressed = 1'b1;
                        click_next      = 1'b1;
                    end
                end
            end
            default:
            begin
                cand_v = '0;
            end
        endcase
    end

    // pack valid candidates to the front of the list, keeping order
    always_comb
    begin
        logic [CNT_W-1:0] cnt;
        cnt    = '0;
        bundle = '0;
        for (int i = 0; i < MAX_EVENTS; i++)
        begin
            if (cand_v[i])
            begin
                bundle.ev[cnt[IDX_W-1:0]] = cand[i];
                cnt = cnt + 1'b1;
            end
        end
        bundle.count = cnt;
    end

    assign in_stall    = queue_full;
    assign accept      = in_valid & ~queue_full;
    assign push        = accept & (bundle.count != '0);
    assign push_bundle = bundle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_DIGITAL;
            on_reg      <= ON_TH_RST;
            off_reg     <= OFF_TH_RST;
            timeout_reg <= TIMEOUT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MODE:    mode_reg    <= cfg_data[1:0];
                REG_ON_TH:   on_reg      <= cfg_data[6:0];
                REG_OFF_TH:  off_reg     <= cfg_data[6:0];
                REG_TIMEOUT: timeout_reg <= cfg_data;
                default:     mode_reg    <= mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg   <= '0;
            start_reg  <= '0;
            click_reg  <= 1'b0;
            motion_reg <= 1'b0;
        end
        else if (accept)
        begin
            held_reg   <= held_next;
            start_reg  <= start_next;
            click_reg  <= click_next;
            motion_reg <= motion_next;
        end
    end

endmodule

FILE: rtl/jkeq_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jkeq_queue
// Short FIFO of event lists between the classifier and the serializer.
// ----------------------------------------------------------------------------
module jkeq_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  jkeq_pkg::bundle_t push_bundle,
    input  logic              pop,
    output logic              full,
    output logic              head_valid,
    output jkeq_pkg::bundle_t head
);
    import jkeq_pkg::*;

    bundle_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign full       = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_bundle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

FILE: rtl/jkeq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jkeq_back
// Walks the head event list into the output register, one word per cycle unless stalled.
// ----------------------------------------------------------------------------
module jkeq_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  jkeq_pkg::bundle_t head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [3:0]        event_code,
    output logic              pressed,
    output logic              last
);
    import jkeq_pkg::*;

    logic [IDX_W-1:0] idx_reg;
    logic             out_valid_reg;
    logic [3:0]       code_reg;
    logic             pressed_reg;
    logic             last_reg;
    logic             load, is_last;
    event_t           cur;

    assign load    = head_valid & (~out_valid_reg | ~out_stall);
    assign cur     = head.ev[idx_reg];
    assign is_last = CNT_W'(idx_reg) == head.count - 1'b1;
    assign pop     = load & is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= is_last ? '0 : idx_reg + 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            code_reg    <= cur.code;
            pressed_reg <= cur.pressed;
            last_reg    <= is_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_code = code_reg;
    assign pressed    = pressed_reg;
    assign last       = last_reg;

endmodule

FILE: rtl/joystick_key_event_qualifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_key_event_qualifier
// Turns joystick samples into ordered key, gamepad and mouse press/release
// events with direction hysteresis and mouse click qualification.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one sample word: x, y, button
//   and millisecond time. The classifier can take a new sample every cycle
//   while the event queue has room.
//   Output channel (out_valid/out_stall) carries one event word per cycle
//   while the receiver does not stall; last marks the final event of a
//   sample. A sample yields 0 to 6 events; samples with no events produce
//   no output words.
//   The first event word of a sample passes through the list queue and then
//   the output register. The output register takes a new word while the
//   previous one is being taken, so the events of a sample leave back to back
//   unless the receiver stalls.
//   A two-entry list queue sits between classifier and serializer; when the
//   receiver stalls, the output word holds and the queue fills, and only then
//   is in_stall raised.
//   Reset clears key state and loads the register defaults (digital mode,
//   thresholds 50/40, hold timeout 500 ms). The user must write registers via
//   cfg_write/cfg_index/cfg_data while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module joystick_key_event_qualifier #(
    parameter int TIME_BITS = jkeq_pkg::TIME_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [jkeq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [jkeq_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [7:0]               sample_x,
    input  logic signed [7:0]               sample_y,
    input  logic                            button_down,
    input  logic [31:0]                     time_ms,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [3:0]                      event_code,
    output logic                            pressed,
    output logic                            last
);
    import jkeq_pkg::*;

    logic    push, pop, queue_full, head_valid;
    bundle_t push_bundle, head;

    jkeq_front #(
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample_x    (sample_x),
        .sample_y    (sample_y),
        .button_down (button_down),
        .time_ms     (time_ms),
        .queue_full  (queue_full),
        .push        (push),
        .push_bundle (push_bundle)
    );

    jkeq_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_bundle (push_bundle),
        .pop         (pop),
        .full        (queue_full),
        .head_valid  (head_valid),
        .head        (head)
    );

    jkeq_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .event_code (event_code),
        .pressed    (pressed),
        .last       (last)
    );

endmodule

FILE: rtl/jkeq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jkeq_checker
// Port-level checks for the joystick key event qualifier.
// ----------------------------------------------------------------------------
module jkeq_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [3:0]                      event_code,
    input logic                            pressed,
    input logic                            last
);
    import jkeq_pkg::*;

    // a stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(event_code)
            && $stable(pressed) && $stable(last))
        else $error("output word changed while stalled");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> event_code <= EV_MOUSE_RIGHT)
        else $error("event code out of range");

    // events of one sample leave back to back
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid)
        else $error("gap inside one sample's events");

    // a left press that is not last is the quick tap: release follows
    a_tap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && event_code == EV_MOUSE_LEFT && pressed && !last
        |=> out_valid && event_code == EV_MOUSE_LEFT && !pressed && last)
        else $error("quick tap not followed by left release");

endmodule

bind joystick_key_event_qualifier jkeq_checker u_jkeq_checker (.*);

FILE: sim/jkeq_scoreboard_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jkeq_scoreboard_pkg
// Event predictor and in-order checker for the joystick key event qualifier:
// mirrors the hysteresis, button and mouse click state of the block and
// compares every event word against the oldest predicted one.
// ----------------------------------------------------------------------------
package jkeq_scoreboard_pkg;

    import jkeq_pkg::*;

    class event_scoreboard;

        typedef struct packed {
            logic [3:0] code;
            logic       pressed;
            logic       last;
        } ev_word_t;

        // register mirror
        logic [1:0]  mode;
        logic [6:0]  on_th;
        logic [6:0]  off_th;
        logic [15:0] hold_to;

        // key state mirror
        logic [4:0]  held;
        logic [31:0] press_t;
        bit          click_on;
        bit          moved_before;

        ev_word_t    expected_q[$];
        ev_word_t    burst_q[$];
        int          errors;
        int          samples;
        int          events;

        function new();
            mode         = MODE_DIGITAL;
            on_th        = ON_TH_RST;
            off_th       = OFF_TH_RST;
            hold_to      = TIMEOUT_RST;
            held         = '0;
            press_t      = '0;
            click_on     = 1'b0;
            moved_before = 1'b0;
            errors       = 0;
            samples      = 0;
            events       = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_MODE:    mode = data[1:0];
                REG_ON_TH:   on_th = data[6:0];
                REG_OFF_TH:  off_th = data[6:0];
                REG_TIMEOUT: hold_to = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void push_event(logic [3:0] code, logic pr);
            ev_word_t w;
            w.code    = code;
            w.pressed = pr;
            w.last    = 1'b0;
            burst_q.push_back(w);
        endfunction

        // one side of one axis; base + flag index gives the event code
        function void track_axis(int v, bit neg, int flag, logic [3:0] base);
            int on_v;
            int off_v;
            bit beyond;
            bit inner;
            on_v   = int'(on_th);
            off_v  = int'(off_th);
            beyond = neg ? (v < -on_v) : (v > on_v);
            inner  = neg ? (v > -off_v) : (v < off_v);
            if (beyond && !held[flag])
            begin
                push_event(base + 4'(flag), 1'b1);
                held[flag] = 1'b1;
            end
            else if (inner && held[flag])
            begin
                push_event(base + 4'(flag), 1'b0);
                held[flag] = 1'b0;
            end
        endfunction

        function void track_button(logic b, bit was_held, logic [3:0] code);
            if (b && !was_held)
            begin
                push_event(code, 1'b1);
                held[FLAG_BTN] = 1'b1;
            end
            else if (!b && was_held)
            begin
                push_event(code, 1'b0);
                held[FLAG_BTN] = 1'b0;
            end
        endfunction

        function void note_sample(logic signed [7:0] x, logic signed [7:0] y, logic b,
                                  logic [31:0] t);
            int          sx;
            int          sy;
            int          on_v;
            bit          was_held;
            bit          moved;
            logic [31:0] elapsed;
            ev_word_t    w;
            sx       = x;
            sy       = y;
            on_v     = int'(on_th);
            was_held = held[FLAG_BTN];
            burst_q.delete();
            samples++;
            case (mode)
                MODE_DIGITAL:
                begin
                    track_axis(sy, 1'b1, FLAG_UP, EV_KEY_UP);
                    track_axis(sy, 1'b0, FLAG_DOWN, EV_KEY_UP);
                    track_axis(sx, 1'b1, FLAG_LEFT, EV_KEY_UP);
                    track_axis(sx, 1'b0, FLAG_RIGHT, EV_KEY_UP);
                    track_button(b, was_held, EV_KEY_BUTTON);
                end
                MODE_ANALOG:
                    track_button(b, was_held, EV_PAD_BUTTON);
                MODE_MOUSE:
                begin
                    moved = (sx < -on_v) || (sx > on_v) || (sy < -on_v) || (sy > on_v);
                    if (was_held && !click_on && moved)
                        moved_before = 1'b1;
                    track_axis(sx, 1'b1, FLAG_LEFT, EV_MOUSE_UP);
                    track_axis(sx, 1'b0, FLAG_RIGHT, EV_MOUSE_UP);
                    track_axis(sy, 1'b1, FLAG_UP, EV_MOUSE_UP);
                    track_axis(sy, 1'b0, FLAG_DOWN, EV_MOUSE_UP);
                    if (b && !was_held)
                    begin
                        press_t        = t;
                        click_on       = 1'b0;
                        moved_before   = 1'b0;
                        held[FLAG_BTN] = 1'b1;
                    end
                    else if (!b && was_held)
                    begin
                        // free the click that was really issued
                        if (click_on)
                            push_event(moved_before ? EV_MOUSE_LEFT : EV_MOUSE_RIGHT, 1'b0);
                        else
                        begin
                            push_event(EV_MOUSE_LEFT, 1'b1);
                            push_event(EV_MOUSE_LEFT, 1'b0);
                        end
                        held[FLAG_BTN] = 1'b0;
                        click_on       = 1'b0;
                        moved_before   = 1'b0;
                    end
                    else if (b && was_held && !click_on)
                    begin
                        elapsed = t - press_t;
                        if (moved)
                        begin
                            moved_before = 1'b1;
                            push_event(EV_MOUSE_LEFT, 1'b1);
                            click_on = 1'b1;
                        end
                        else if (elapsed >= {16'b0, hold_to})
                        begin
                            push_event(EV_MOUSE_RIGHT, 1'b1);
                            click_on = 1'b1;
                        end
                    end
                end
                default: ; // unused mode: sample dropped, state untouched
            endcase
            if (burst_q.size() > 0)
            begin
                w      = burst_q.pop_back();
                w.last = 1'b1;
                burst_q.push_back(w);
            end
            foreach (burst_q[i])
                expected_q.push_back(burst_q[i]);
        endfunction

        function void check_event(logic [3:0] code, logic pr, logic lst);
            ev_word_t w;
            events++;
            if (expected_q.size() == 0)
            begin
                $error("unexpected event word: code %0d pressed %0b last %0b", code, pr, lst);
                errors++;
                return;
            end
            w = expected_q.pop_front();
            if (code !== w.code)
            begin
                $error("event_code: expected %0d, got %0d", w.code, code);
                errors++;
            end
            if (pr !== w.pressed)
            begin
                $error("pressed: expected %0b, got %0b", w.pressed, pr);
                errors++;
            end
            if (lst !== w.last)
            begin
                $error("last: expected %0b, got %0b", w.last, lst);
                errors++;
            end
        endfunction

        function void close();
            if (expected_q.size() != 0)
            begin
                $error("%0d expected event words never arrived", expected_q.size());
                errors++;
            end
        endfunction

    endclass

endpackage

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for joystick_key_event_qualifier: directed samples for
// thresholds, mode switches and every click outcome, then random sample
// streams over several register settings and handshake pressure profiles.
// ----------------------------------------------------------------------------
module tb_top;

    import jkeq_pkg::*;
    import jkeq_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int QUIET_CYCLES = 16;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 48;

    // mode value with no function
    localparam logic [1:0] MODE_NONE = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic signed [7:0]     sample_x = '0;
    logic signed [7:0]     sample_y = '0;
    logic                  button_down = 1'b0;
    logic [31:0]           time_ms = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [3:0]            event_code;
    logic                  pressed;
    logic                  last;

    int                    idle_pct = 0;
    int                    stall_pct = 0;
    int                    cycle_count = 0;
    event_scoreboard       sb;

    joystick_key_event_qualifier DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample_x    (sample_x),
        .sample_y    (sample_y),
        .button_down (button_down),
        .time_ms     (time_ms),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_code  (event_code),
        .pressed     (pressed),
        .last        (last)
    );

    always #10 clk = ~clk;

    always @(negedge clk)
        out_stall <= (int'($urandom_range(99)) < stall_pct);

    // both channels are observed at the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_event(event_code, pressed, last);
            if (in_valid && !in_stall)
                sb.note_sample(sample_x, sample_y, button_down, time_ms);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic send_sample(logic signed [7:0] x, logic signed [7:0] y, logic b,
                               logic [31:0] t);
        @(negedge clk);
        if (int'($urandom_range(99)) < idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while (int'($urandom_range(99)) < idle_pct);
        end
        in_valid    <= 1'b1;
        sample_x    <= x;
        sample_y    <= y;
        button_down <= b;
        time_ms     <= t;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    // drop valid, wait for all words, then cover samples that give no word
    task automatic wait_quiet();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    function automatic logic signed [7:0] pick_axis(int on_v, int off_v);
        int v;
        case ($urandom_range(7))
            0, 1: v = int'($urandom_range(10)) - 5;
            2:    v = on_v + int'($urandom_range(2)) - 1;
            3:    v = off_v + int'($urandom_range(2)) - 1;
            4:    v = 128;
            default: v = int'($urandom_range(255)) - 128;
        endcase
        if ($urandom_range(1) == 1)
            v = -v;
        if (v > 127)
            v = 127;
        if (v < -128)
            v = -128;
        return 8'(v);
    endfunction

    initial
    begin : main
        logic [1:0]  mode_tab [PHASES];
        int          on_tab [PHASES];
        int          off_tab [PHASES];
        int          to_tab [PHASES];
        int          on_cur;
        int          off_cur;
        int          to_cur;
        logic [31:0] now;
        logic        btn;

        mode_tab = '{MODE_MOUSE, MODE_DIGITAL, MODE_ANALOG, MODE_MOUSE,
                     MODE_MOUSE, MODE_DIGITAL, MODE_MOUSE, MODE_ANALOG};
        on_tab   = '{50, 0, 127, 30, 100, 127, 0, 0};
        off_tab  = '{40, 0, 127, 60, 10, 0, 127, 0};
        to_tab   = '{500, 0, 65535, 20, 5, 1, 0, 0};
        sb = new();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // digital keys at reset thresholds, strict compare edges
        send_sample(8'sd0, 8'sd0, 1'b0, 32'd0);
        send_sample(8'sd0, -8'sd51, 1'b0, 32'd1);
        send_sample(8'sd0, -8'sd40, 1'b0, 32'd2);
        send_sample(8'sd0, -8'sd39, 1'b0, 32'd3);
        send_sample(8'sd0, -8'sd50, 1'b0, 32'd4);
        send_sample(8'sd0, -8'sd128, 1'b0, 32'd5);
        send_sample(-8'sd128, 8'sd127, 1'b1, 32'd6);
        send_sample(8'sd127, 8'sd0, 1'b0, 32'd7);
        send_sample(8'sd0, -8'sd128, 1'b1, 32'd8);

        // analog: button held from digital is released with the pad code
        wait_quiet();
        write_reg(REG_MODE, {14'b0, MODE_ANALOG});
        send_sample(8'sd0, 8'sd0, 1'b0, 32'd9);
        send_sample(8'sd127, 8'sd127, 1'b1, 32'd10);
        send_sample(8'sd0, 8'sd0, 1'b0, 32'd11);

        // mouse: up still held from digital, then every click outcome
        wait_quiet();
        write_reg(REG_MODE, {14'b0, MODE_MOUSE});
        send_sample(8'sd0, 8'sd0, 1'b1, 32'd1000);
        send_sample(8'sd0, 8'sd0, 1'b1, 32'd1499);
        send_sample(8'sd0, 8'sd0, 1'b1, 32'd1500);
        send_sample(8'sd127, 8'sd0, 1'b1, 32'd1501);   // motion after right click
        send_sample(8'sd0, 8'sd0, 1'b0, 32'd1502);
        send_sample(8'sd0, 8'sd0, 1'b1, 32'd2000);
        send_sample(-8'sd128, 8'sd0, 1'b1, 32'd2001);
        send_sample(-8'sd128, 8'sd127, 1'b0, 32'd2002);
        send_sample(-8'sd128, 8'sd127, 1'b1, 32'd2003);
        send_sample(8'sd127, -8'sd128, 1'b0, 32'd2004); // six words, quick click
        send_sample(8'sd0, 8'sd0, 1'b1, 32'hFFFF_FF00);
        send_sample(8'sd0, 8'sd0, 1'b1, 32'h0000_0100); // hold timer across wrap
        send_sample(8'sd0, 8'sd0, 1'b0, 32'h0000_0101);

        // unused mode drops the sample
        wait_quiet();
        write_reg(REG_MODE, {14'b0, MODE_NONE});
        send_sample(8'sd127, 8'sd127, 1'b1, 32'd3000);

        now = $urandom();
        btn = 1'b0;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_quiet();
            on_cur  = on_tab[ph];
            off_cur = off_tab[ph];
            to_cur  = to_tab[ph];
            if (ph == PHASES - 1)
            begin
                on_cur  = $urandom_range(127);
                off_cur = $urandom_range(127);
                to_cur  = $urandom_range(65535);
            end
            write_reg(REG_MODE, {14'b0, mode_tab[ph]});
            write_reg(REG_ON_TH, 16'(on_cur));
            write_reg(REG_OFF_TH, 16'(off_cur));
            write_reg(REG_TIMEOUT, 16'(to_cur));
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 77; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 77; end
                default: begin idle_pct = 33; stall_pct = 33; end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(99) < 30)
                    btn = ~btn;
                if ($urandom_range(19) == 0)
                    now = $urandom();
                else
                    now = now + 32'($urandom_range(to_cur / 3 + 2));
                send_sample(pick_axis(on_cur, off_cur), pick_axis(on_cur, off_cur), btn, now);
            end
        end

        wait_quiet();
        sb.close();
        $display("summary: %0d samples accepted, %0d event words checked", sb.samples, sb.events);
        $display("summary: directed cases, then %0d register settings under 4 handshake profiles",
                 PHASES);
        if (sb.errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
